@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file rdc_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is high
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// overlapping implication with reset disable
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication with reset disable
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rdc_pkg.sv @@
`default_nettype none

package rdc_pkg;

   localparam int NUM_W      = 31;
   localparam int ERR_W      = 2;
   localparam int SEL_W      = 2;
   localparam int NUM_BCD    = 10;
   localparam int NIB_W      = 4;
   localparam int CNT_W      = 4;
   localparam int BIT_CNT_W  = 5;
   localparam int ENC_W      = 34;
   localparam int SCALE_W    = NUM_W + 4;

   localparam logic [NUM_W-1:0] RESULT_MAX = {NUM_W{1'b1}};
   localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(NUM_W - 1);

   localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DIGIT    = 2'd1;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

   localparam logic [SEL_W-1:0] BASE_BIN = 2'd0;
   localparam logic [SEL_W-1:0] BASE_OCT = 2'd1;
   localparam logic [SEL_W-1:0] BASE_DEC = 2'd2;
   localparam logic [SEL_W-1:0] BASE_HEX = 2'd3;

   localparam logic REG_SRC = 1'b0;
   localparam logic REG_TGT = 1'b1;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DABBLE,
      OP_HORNER,
      OP_PLACE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [CNT_W-1:0]   dig;
      logic [SEL_W-1:0]   base;
      logic               tgt_oct;
   } ctrl_type;

   typedef struct packed {
      logic               bad;
      logic               val_zero;
      logic               enc_over;
      logic [NUM_W-1:0]   value;
      logic [NUM_W-1:0]   enc;
   } status_type;

   function automatic logic [ENC_W-1:0] pow10_f(input logic [CNT_W-1:0] pos);
      logic [ENC_W-1:0] p;
      unique case (pos)
         4'd0:    p = ENC_W'(64'd1);
         4'd1:    p = ENC_W'(64'd10);
         4'd2:    p = ENC_W'(64'd100);
         4'd3:    p = ENC_W'(64'd1000);
         4'd4:    p = ENC_W'(64'd10000);
         4'd5:    p = ENC_W'(64'd100000);
         4'd6:    p = ENC_W'(64'd1000000);
         4'd7:    p = ENC_W'(64'd10000000);
         4'd8:    p = ENC_W'(64'd100000000);
         4'd9:    p = ENC_W'(64'd1000000000);
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

@@ rtl/radix_digit_converter_core.sv @@
// order of work for each accepted item, on one shared digit unit: 31 double-dabble steps,
//    one horner step per source digit, then, for a binary or octal target without a bad digit,
//    one placement step per target digit, plus waits while a held result is not taken
// one item at a time: req_tready is low while an item is converted and returns as the result
//    is registered
// reset: synchronous active high, selectors return to decimal, output register empties
`default_nettype none

module radix_digit_converter_core import rdc_pkg::*; #(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [31:0]       req_tdata,   // number[30:0], zero pad[31]
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [31:0]            rsp_tdata,   // result[30:0], zero pad[31]
   output logic [ERR_W-1:0]       rsp_tuser,   // error[1:0]
   input  wire logic              csr_we,
   input  wire logic              csr_addr,
   input  wire logic [SEL_W-1:0]  csr_wdata
);

   localparam logic [CNT_W-1:0] LAST_DIG = CNT_W'(MAX_DIGITS - 1);
   localparam logic [CNT_W-1:0] NUM_DIG  = CNT_W'(MAX_DIGITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_BCD,
      S_READ,
      S_EVAL,
      S_WRITE,
      S_DONE
   } state_type;

   state_type              state_ff;
   logic [SEL_W-1:0]       src_ff;
   logic [SEL_W-1:0]       tgt_ff;
   logic [BIT_CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]       dig_ff;
   logic [NUM_W-1:0]       res_ff;
   logic [ERR_W-1:0]       err_ff;
   logic                   rsp_valid_ff;
   logic [NUM_W-1:0]       rsp_res_ff;
   logic [ERR_W-1:0]       rsp_err_ff;

   ctrl_type               ctrl;
   status_type             status;
   logic                   accept;
   logic                   out_free;

   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      ctrl.dig     = dig_ff;
      ctrl.base    = src_ff;
      ctrl.tgt_oct = (tgt_ff == BASE_OCT);
      unique case (state_ff)
         S_IDLE:  ctrl.op = accept ? OP_LOAD : OP_NOP;
         S_BCD:   ctrl.op = OP_DABBLE;
         S_READ:  ctrl.op = OP_HORNER;
         S_WRITE: ctrl.op = (!status.val_zero && dig_ff < NUM_DIG) ? OP_PLACE : OP_NOP;
         default: ctrl.op = OP_NOP;
      endcase
   end

   rdc_datapath u_datapath (
      .clock  (clock),
      .ctrl   (ctrl),
      .number (req_tdata[NUM_W-1:0]),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         src_ff       <= BASE_DEC;
         tgt_ff       <= BASE_DEC;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         dig_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_SRC: src_ff <= csr_wdata;
               REG_TGT: tgt_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  cnt_ff   <= LAST_BIT;
                  state_ff <= S_BCD;
               end
            end
            S_BCD: begin
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  dig_ff   <= LAST_DIG;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               dig_ff <= dig_ff - 1'b1;
               if (dig_ff == '0) begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               if (status.bad) begin
                  res_ff   <= '0;
                  err_ff   <= ERR_DIGIT;
                  state_ff <= S_DONE;
               end else if (tgt_ff == BASE_BIN || tgt_ff == BASE_OCT) begin
                  dig_ff   <= '0;
                  state_ff <= S_WRITE;
               end else begin
                  res_ff   <= status.value;
                  err_ff   <= ERR_OK;
                  state_ff <= S_DONE;
               end
            end
            S_WRITE: begin
               if (status.val_zero) begin
                  res_ff   <= status.enc_over ? '0 : status.enc;
                  err_ff   <= status.enc_over ? ERR_OVERFLOW : ERR_OK;
                  state_ff <= S_DONE;
               end else if (dig_ff >= NUM_DIG) begin
                  res_ff   <= '0;
                  err_ff   <= ERR_OVERFLOW;
                  state_ff <= S_DONE;
               end else begin
                  dig_ff <= dig_ff + 1'b1;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_res_ff   <= res_ff;
                  rsp_err_ff   <= err_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_res_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule

`default_nettype wire

@@ rtl/rdc_datapath.sv @@
`default_nettype none

module rdc_datapath import rdc_pkg::*; (
   input  wire logic              clock,
   input  wire ctrl_type          ctrl,
   input  wire logic [NUM_W-1:0]  number,
   output status_type             status
);

   logic [NUM_W-1:0]  bin_ff;
   logic [NIB_W-1:0]  bcd_ff [NUM_BCD];
   logic [NIB_W-1:0]  bcd_in [NUM_BCD];
   logic [NIB_W-1:0]  adj    [NUM_BCD];
   logic [NUM_W-1:0]  acc_ff;
   logic [ENC_W-1:0]  enc_ff;
   logic              bad_ff;

   logic [NIB_W-1:0]   digit;
   logic [NIB_W-1:0]   max_digit;
   logic [SCALE_W-1:0] scaled;
   logic [2:0]         pdig;
   logic [ENC_W-1:0]   term;
   logic [NUM_W-1:0]   acc_shift;

   // add-3 correction then shift one binary bit into the digit chain
   always_comb begin
      for (int i = 0; i < NUM_BCD; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_in[0] = {adj[0][2:0], bin_ff[NUM_W-1]};
      for (int i = 1; i < NUM_BCD; i++) begin
         bcd_in[i] = {adj[i][2:0], adj[i-1][3]};
      end
   end

   // horner step over source digits, most significant first
   always_comb begin
      digit = (ctrl.dig < CNT_W'(NUM_BCD)) ? bcd_ff[ctrl.dig] : '0;
      unique case (ctrl.base)
         BASE_BIN: begin
            max_digit = 4'd1;
            scaled    = SCALE_W'({acc_ff, 1'b0});
         end
         BASE_OCT: begin
            max_digit = 4'd7;
            scaled    = SCALE_W'({acc_ff, 3'b000});
         end
         default: begin
            max_digit = 4'd9;
            scaled    = SCALE_W'({acc_ff, 3'b000}) + SCALE_W'({acc_ff, 1'b0});
         end
      endcase
      scaled = scaled + SCALE_W'(digit);
   end

   // target digit placement as decimal digit
   always_comb begin
      pdig      = ctrl.tgt_oct ? acc_ff[2:0] : {2'b00, acc_ff[0]};
      term      = ENC_W'(pdig) * pow10_f(ctrl.dig);
      acc_shift = ctrl.tgt_oct ? (acc_ff >> 3) : (acc_ff >> 1);
   end

   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_NOP: begin
         end
         OP_LOAD: begin
            bin_ff <= number;
            for (int i = 0; i < NUM_BCD; i++) begin
               bcd_ff[i] <= '0;
            end
            acc_ff <= '0;
            enc_ff <= '0;
            bad_ff <= 1'b0;
         end
         OP_DABBLE: begin
            bin_ff <= bin_ff << 1;
            for (int i = 0; i < NUM_BCD; i++) begin
               bcd_ff[i] <= bcd_in[i];
            end
         end
         OP_HORNER: begin
            acc_ff <= scaled[NUM_W-1:0];
            if (digit > max_digit) begin
               bad_ff <= 1'b1;
            end
         end
         OP_PLACE: begin
            enc_ff <= enc_ff + term;
            acc_ff <= acc_shift;
         end
         default: begin
         end
      endcase
   end

   assign status.bad      = bad_ff;
   assign status.val_zero = (acc_ff == '0);
   assign status.enc_over = (enc_ff > ENC_W'(RESULT_MAX));
   assign status.value    = acc_ff;
   assign status.enc      = enc_ff[NUM_W-1:0];

endmodule

`default_nettype wire

@@ rtl/rdc_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module rdc_checker import rdc_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [31:0]       rsp_tdata,
   input wire logic [ERR_W-1:0]  rsp_tuser
);

   `ASSERT_IMPLIES(a_err_zero_result, clock, reset, rsp_tvalid && rsp_tuser != ERR_OK, rsp_tdata == '0, "result not zero on error")
   `ASSERT_IMPLIES(a_err_code_legal, clock, reset, rsp_tvalid, rsp_tuser == ERR_OK || rsp_tuser == ERR_DIGIT || rsp_tuser == ERR_OVERFLOW, "bad error code")
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready && !$rose(rsp_tvalid), "item overlap after accept")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled item changed")

endmodule

bind radix_digit_converter_core rdc_checker u_rdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
   import rdc_pkg::*;

   localparam int DIGIT_WINDOW = 10;
   localparam int DIRECTED_N   = 25;
   localparam int BLOCKS       = 19;
   localparam int BLOCK_ITEMS  = 100;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int SETTLE_WAIT  = 4;
   localparam int END_WAIT     = 80;

   typedef struct packed {
      logic [NUM_W-1:0] result;
      logic [ERR_W-1:0] error;
   } conv_out_type;

   typedef struct packed {
      logic [SEL_W-1:0] src;
      logic [SEL_W-1:0] tgt;
      logic [NUM_W-1:0] number;
      logic             typed;
      logic [NUM_W-1:0] result;
      logic [ERR_W-1:0] error;
   } dir_row_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [ERR_W-1:0]  rsp_tuser;
   logic              csr_we      = 1'b0;
   logic              csr_addr    = REG_SRC;
   logic [SEL_W-1:0]  csr_wdata   = '0;

   logic [SEL_W-1:0]  src_base = BASE_DEC;
   logic [SEL_W-1:0]  tgt_base = BASE_DEC;
   conv_out_type      pending_conv[$];
   conv_out_type      got_want;
   int                send_idle_pct  = 0;
   int                recv_stall_pct = 0;
   int                fail_count     = 0;
   int                cycle_count    = 0;
   int                items_sent     = 0;
   int                settings_used  = 0;
   int                digit_errs     = 0;
   int                overflows      = 0;

   dir_row_type directed_rows [DIRECTED_N] = '{
      '{BASE_DEC, BASE_DEC, 31'd0,          1'b1, 31'd0,          ERR_OK},
      '{BASE_DEC, BASE_DEC, 31'd2147483647, 1'b1, 31'd2147483647, ERR_OK},
      '{BASE_BIN, BASE_DEC, 31'd1111111111, 1'b1, 31'd1023,       ERR_OK},
      '{BASE_BIN, BASE_HEX, 31'd1010,       1'b1, 31'd10,         ERR_OK},
      '{BASE_BIN, BASE_DEC, 31'd2,          1'b1, 31'd0,          ERR_DIGIT},
      '{BASE_BIN, BASE_BIN, 31'd1111111111, 1'b1, 31'd1111111111, ERR_OK},
      '{BASE_BIN, BASE_BIN, 31'd0,          1'b1, 31'd0,          ERR_OK},
      '{BASE_BIN, BASE_OCT, 31'd1111111111, 1'b1, 31'd1777,       ERR_OK},
      '{BASE_BIN, BASE_OCT, 31'd1000000000, 1'b1, 31'd1000,       ERR_OK},
      '{BASE_OCT, BASE_DEC, 31'd777,        1'b1, 31'd511,        ERR_OK},
      '{BASE_OCT, BASE_DEC, 31'd8,          1'b1, 31'd0,          ERR_DIGIT},
      '{BASE_OCT, BASE_DEC, 31'd2147483647, 1'b1, 31'd0,          ERR_DIGIT},
      '{BASE_OCT, BASE_BIN, 31'd1777,       1'b1, 31'd1111111111, ERR_OK},
      '{BASE_OCT, BASE_BIN, 31'd2000,       1'b1, 31'd0,          ERR_OVERFLOW},
      '{BASE_OCT, BASE_BIN, 31'd1777777777, 1'b1, 31'd0,          ERR_OVERFLOW},
      '{BASE_OCT, BASE_BIN, 31'd1777777778, 1'b1, 31'd0,          ERR_DIGIT},
      '{BASE_OCT, BASE_HEX, 31'd7654321,    1'b0, 31'd0,          ERR_OK},
      '{BASE_DEC, BASE_BIN, 31'd1023,       1'b1, 31'd1111111111, ERR_OK},
      '{BASE_DEC, BASE_BIN, 31'd1024,       1'b1, 31'd0,          ERR_OVERFLOW},
      '{BASE_DEC, BASE_OCT, 31'd268435455,  1'b1, 31'd1777777777, ERR_OK},
      '{BASE_DEC, BASE_OCT, 31'd1073741823, 1'b1, 31'd0,          ERR_OVERFLOW},
      '{BASE_DEC, BASE_OCT, 31'd2147483647, 1'b1, 31'd0,          ERR_OVERFLOW},
      '{BASE_HEX, BASE_DEC, 31'd999,        1'b1, 31'd999,        ERR_OK},
      '{BASE_HEX, BASE_HEX, 31'd305419896,  1'b0, 31'd0,          ERR_OK},
      '{BASE_HEX, BASE_HEX, 31'd0,          1'b1, 31'd0,          ERR_OK}
   };

   radix_digit_converter_core #(.MAX_DIGITS(DIGIT_WINDOW)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic conv_out_type convert_number(input logic [NUM_W-1:0] number,
                                                   input logic [SEL_W-1:0] src,
                                                   input logic [SEL_W-1:0] tgt);
      longint unsigned digits, span, value, weight, radix, out_radix, enc, scale, rest;
      int i, pos;
      logic bad, over;
      conv_out_type c;
      span = 1;
      for (i = 0; i < DIGIT_WINDOW; i++) span = span * 10;
      digits = longint'(number) % span;
      radix = (src == BASE_BIN) ? 2 : (src == BASE_OCT) ? 8 : 10;
      value = 0;
      weight = 1;
      bad = 1'b0;
      for (i = 0; i < DIGIT_WINDOW; i++) begin
         if (digits % 10 >= radix) bad = 1'b1;
         value = value + (digits % 10) * weight;
         weight = weight * radix;
         digits = digits / 10;
      end
      c.result = '0;
      c.error = ERR_OK;
      if (bad) begin
         c.error = ERR_DIGIT;
      end else if (tgt == BASE_BIN || tgt == BASE_OCT) begin
         out_radix = (tgt == BASE_BIN) ? 2 : 8;
         enc = 0;
         scale = 1;
         pos = 0;
         over = 1'b0;
         rest = value;
         while (rest != 0 && !over) begin
            if (pos >= DIGIT_WINDOW) begin
               over = 1'b1;
            end else begin
               enc = enc + (rest % out_radix) * scale;
               scale = scale * 10;
               rest = rest / out_radix;
               pos++;
            end
         end
         if (enc > RESULT_MAX) over = 1'b1;
         if (over) c.error = ERR_OVERFLOW;
         else c.result = enc[NUM_W-1:0];
      end else begin
         c.result = value[NUM_W-1:0];
      end
      return c;
   endfunction

   // mostly digits valid in source base, some bin/oct with one bad digit, some raw noise
   function automatic logic [NUM_W-1:0] gen_number(input logic [SEL_W-1:0] src);
      longint unsigned num;
      int pick, top, ndig, bad_at, i;
      pick = $urandom_range(99);
      if (pick < 3) return '0;
      if (pick < 15) return NUM_W'($urandom());
      top = (src == BASE_BIN) ? 1 : (src == BASE_OCT) ? 7 : 9;
      ndig = ($urandom_range(1) == 1) ? $urandom_range(1, 4) : $urandom_range(1, DIGIT_WINDOW);
      bad_at = (pick < 27 && top < 9) ? $urandom_range(ndig - 1) : -1;
      num = 0;
      for (i = 0; i < ndig; i++) begin
         if (i == bad_at) num = num * 10 + $urandom_range(9, top + 1);
         else num = num * 10 + $urandom_range(top);
      end
      if (num > RESULT_MAX) num = num % 1000000000;
      return num[NUM_W-1:0];
   endfunction

   function automatic void note_fail(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   task automatic send_number(input logic [NUM_W-1:0] number, input conv_out_type want);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, number};
      do @(posedge clock); while (!req_tready);
      pending_conv.push_back(want);
      items_sent++;
      if (want.error == ERR_DIGIT) digit_errs++;
      if (want.error == ERR_OVERFLOW) overflows++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_conv.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // block must be idle here
   task automatic set_bases(input logic [SEL_W-1:0] src, input logic [SEL_W-1:0] tgt);
      wait_drained();
      csr_we    <= 1'b1;
      csr_addr  <= REG_SRC;
      csr_wdata <= src;
      @(posedge clock);
      csr_addr  <= REG_TGT;
      csr_wdata <= tgt;
      @(posedge clock);
      csr_we    <= 1'b0;
      src_base = src;
      tgt_base = tgt;
      settings_used++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d items outstanding",
                  cycle_count, pending_conv.size());
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_conv.size() == 0) begin
               note_fail($sformatf("unexpected item: result %0d error %0d",
                                   rsp_tdata[NUM_W-1:0], rsp_tuser));
            end else begin
               got_want = pending_conv.pop_front();
               if (rsp_tdata[NUM_W-1:0] !== got_want.result || rsp_tuser !== got_want.error)
                  note_fail($sformatf("mismatch: result %0d error %0d, expected %0d error %0d",
                                      rsp_tdata[NUM_W-1:0], rsp_tuser,
                                      got_want.result, got_want.error));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      int r, blk, k;
      dir_row_type row;
      conv_out_type want;
      logic [SEL_W-1:0] src, tgt;
      logic [NUM_W-1:0] number;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows, first ones run on the reset settings
      for (r = 0; r < DIRECTED_N; r++) begin
         row = directed_rows[r];
         if (row.src != src_base || row.tgt != tgt_base) set_bases(row.src, row.tgt);
         if (row.typed) begin
            want.result = row.result;
            want.error  = row.error;
         end else begin
            want = convert_number(row.number, src_base, tgt_base);
         end
         send_number(row.number, want);
      end

      for (blk = 0; blk < BLOCKS; blk++) begin
         case (blk)
            0: begin
               src = BASE_BIN;
               tgt = BASE_BIN;
            end
            1: begin
               src = BASE_HEX;
               tgt = BASE_HEX;
            end
            2: begin
               src = BASE_OCT;
               tgt = BASE_BIN;
            end
            3: begin
               src = BASE_BIN;
               tgt = BASE_OCT;
            end
            default: begin
               src = SEL_W'($urandom_range(3));
               tgt = SEL_W'($urandom_range(3));
            end
         endcase
         // waits for every outstanding item before the write
         set_bases(src, tgt);
         case (blk % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 64;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 64;
            end
            default: begin
               send_idle_pct  = 36;
               recv_stall_pct = 36;
            end
         endcase
         for (k = 0; k < BLOCK_ITEMS; k++) begin
            number = gen_number(src_base);
            send_number(number, convert_number(number, src_base, tgt_base));
         end
      end

      wait_drained();
      repeat (END_WAIT) @(posedge clock);

      $display("ran %0d items over %0d base settings in %0d cycles",
               items_sent, settings_used, cycle_count);
      $display("%0d invalid-digit and %0d overflow items included, %0d failures",
               digit_errs, overflows, fail_count);
      if (fail_count == 0 && pending_conv.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rdc_pkg.sv
rtl/rdc_datapath.sv
rtl/radix_digit_converter_core.sv
rtl/rdc_checker.sv
sim/testbench.sv
